@@ hdl/dxt_endpoint_range_histogram_assert.svh @@
// Assertion macros for the endpoint range histogram
`ifndef DXT_ENDPOINT_RANGE_HISTOGRAM_ASSERT_SVH
`define DXT_ENDPOINT_RANGE_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define DERH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define DERH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define DERH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define DERH_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/derh_pkg.sv @@
// Shared types and constants of the endpoint range histogram
package derh_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int OUT_COUNT_BITS  = 24;
    localparam int PACKED_BITS     = 16;
    localparam int RED_BITS        = 5;
    localparam int GREEN_BITS      = 6;
    localparam int BLUE_BITS       = 5;
    localparam int BIN_IDX_BITS    = 6;
    localparam int RED_BINS        = 32;
    localparam int BLUE_BINS       = 32;
    localparam int KIND_BITS       = 2;
    localparam int CHAN_BITS       = 2;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 1;
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 4;

    localparam logic [KIND_BITS-1:0] KIND_ACC     = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;

    localparam logic [CHAN_BITS-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_BITS-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_BITS-1:0] CH_BLUE  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_RED_EN   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GREEN_EN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLUE_EN  = 2'd2;

    localparam logic [RED_BITS-1:0]   RED_LOW_RST    = '1;
    localparam logic [GREEN_BITS-1:0] GREEN_LOW_RST  = '1;
    localparam logic [BLUE_BITS-1:0]  BLUE_LOW_RST   = '1;
    localparam logic [RED_BITS-1:0]   RED_HIGH_RST   = '0;
    localparam logic [GREEN_BITS-1:0] GREEN_HIGH_RST = '0;
    localparam logic [BLUE_BITS-1:0]  BLUE_HIGH_RST  = '0;

    typedef struct packed {
        logic                    acc;
        logic                    restart;
        logic                    rd_red;
        logic                    rd_green;
        logic                    rd_blue;
        logic [RED_BITS-1:0]     red0;
        logic [GREEN_BITS-1:0]   green0;
        logic [BLUE_BITS-1:0]    blue0;
        logic [RED_BITS-1:0]     red1;
        logic [GREEN_BITS-1:0]   green1;
        logic [BLUE_BITS-1:0]    blue1;
        logic [BIN_IDX_BITS-1:0] bin;
    } t_cmd;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } t_hist_en;

    typedef struct packed {
        logic [PACKED_BITS-1:0]    min_packed;
        logic [PACKED_BITS-1:0]    max_packed;
        logic [OUT_COUNT_BITS-1:0] bin_count;
    } t_result;

    typedef struct packed {
        logic issue;
        logic s2_vld;
        logic out_full;
    } t_back_status;

endpackage

@@ hdl/derh_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module derh_ram #(
    parameter int WIDTH = derh_pkg::COUNT_BITS_DEF,
    parameter int DEPTH = derh_pkg::RED_BINS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/derh_fifo.sv @@
// Small register FIFO used as command queue and result queue
module derh_fifo #(
    parameter int WIDTH = $bits(derh_pkg::t_cmd),
    parameter int DEPTH = derh_pkg::CMD_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_count = r_count;

endmodule

@@ hdl/derh_front.sv @@
// Front stage: accept input items and decode them into commands
module derh_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [derh_pkg::KIND_BITS-1:0]      i_kind,
    input  logic [derh_pkg::RED_BITS-1:0]       i_red0,
    input  logic [derh_pkg::GREEN_BITS-1:0]     i_green0,
    input  logic [derh_pkg::BLUE_BITS-1:0]      i_blue0,
    input  logic [derh_pkg::RED_BITS-1:0]       i_red1,
    input  logic [derh_pkg::GREEN_BITS-1:0]     i_green1,
    input  logic [derh_pkg::BLUE_BITS-1:0]      i_blue1,
    input  logic [derh_pkg::CHAN_BITS-1:0]      i_channel,
    input  logic [derh_pkg::BIN_IDX_BITS-1:0]   i_bin,
    input  logic                                i_full,
    output logic                                o_push,
    output derh_pkg::t_cmd                      o_cmd
);

    logic           r_vld;
    derh_pkg::t_cmd r_cmd;
    derh_pkg::t_cmd n_cmd;
    logic           rd;
    logic           accept;

    always_comb begin
        rd             = (i_kind == derh_pkg::KIND_READ);
        n_cmd.acc      = (i_kind == derh_pkg::KIND_ACC);
        n_cmd.restart  = (i_kind == derh_pkg::KIND_RESTART);
        n_cmd.rd_red   = rd && (i_channel == derh_pkg::CH_RED)
                         && (i_bin < derh_pkg::BIN_IDX_BITS'(derh_pkg::RED_BINS));
        n_cmd.rd_green = rd && (i_channel == derh_pkg::CH_GREEN);
        n_cmd.rd_blue  = rd && (i_channel == derh_pkg::CH_BLUE)
                         && (i_bin < derh_pkg::BIN_IDX_BITS'(derh_pkg::BLUE_BINS));
        n_cmd.red0     = i_red0;
        n_cmd.green0   = i_green0;
        n_cmd.blue0    = i_blue0;
        n_cmd.red1     = i_red1;
        n_cmd.green1   = i_green1;
        n_cmd.blue1    = i_blue1;
        n_cmd.bin      = i_bin;
    end

    assign o_stall = r_vld && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld && !i_full;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ hdl/derh_hist.sv @@
// One channel histogram: two RAM banks, one per endpoint, with valid bits
module derh_hist #(
    parameter int BIN_BITS   = derh_pkg::RED_BITS,
    parameter int COUNT_BITS = derh_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [BIN_BITS-1:0]   i_raddr_a,
    input  logic [BIN_BITS-1:0]   i_raddr_b,
    input  logic                  i_acc,
    input  logic                  i_clear,
    output logic [COUNT_BITS-1:0] o_count
);

    localparam int DEPTH = 2 ** BIN_BITS;
    localparam logic [COUNT_BITS-1:0] LIMIT = '1;

    logic [1:0][BIN_BITS-1:0]   raddr;
    logic [1:0][COUNT_BITS-1:0] cur;
    logic [COUNT_BITS:0]        sum;

    assign raddr = {i_raddr_b, i_raddr_a};

    for (genvar g = 0; g < 2; g++) begin : g_bank
        logic [BIN_BITS-1:0]   r_addr;
        logic [DEPTH-1:0]      r_valid;
        logic                  r_fwd_vld;
        logic [BIN_BITS-1:0]   r_fwd_addr;
        logic [COUNT_BITS-1:0] r_fwd_val;
        logic [COUNT_BITS-1:0] rdata;
        logic [COUNT_BITS-1:0] n_val;

        derh_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_acc),
            .i_waddr (r_addr),
            .i_wdata (n_val),
            .i_raddr (raddr[g]),
            .o_rdata (rdata)
        );

        always_comb begin
            if (r_fwd_vld && (r_fwd_addr == r_addr)) begin
                cur[g] = r_fwd_val;
            end else if (r_valid[r_addr]) begin
                cur[g] = rdata;
            end else begin
                cur[g] = '0;
            end
            n_val = (cur[g] == LIMIT) ? cur[g] : cur[g] + COUNT_BITS'(1);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid   <= '0;
                r_fwd_vld <= 1'b0;
            end else if (i_clear) begin
                r_valid   <= '0;
                r_fwd_vld <= 1'b0;
            end else begin
                r_fwd_vld <= i_acc;
                if (i_acc) begin
                    r_valid[r_addr] <= 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_addr <= raddr[g];
            if (i_acc) begin
                r_fwd_addr <= r_addr;
                r_fwd_val  <= n_val;
            end
        end
    end

    assign sum     = {1'b0, cur[0]} + {1'b0, cur[1]};
    assign o_count = sum[COUNT_BITS] ? LIMIT : sum[COUNT_BITS-1:0];

endmodule

@@ hdl/derh_back.sv @@
// Back end: histogram update and lookup, extremes tracking, result queue
module derh_back #(
    parameter int COUNT_BITS = derh_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  derh_pkg::t_hist_en    i_en,
    input  derh_pkg::t_cmd        i_cmd,
    input  logic                  i_cmd_empty,
    output logic                  o_cmd_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output derh_pkg::t_result     o_result,
    output derh_pkg::t_back_status o_status
);

    localparam int OUT_DEPTH = derh_pkg::OUT_QUEUE_DEPTH;
    localparam int CNT_BITS  = $clog2(OUT_DEPTH + 1);
    localparam int OUT_BITS  = derh_pkg::OUT_COUNT_BITS;

    logic                              r_s2_vld;
    derh_pkg::t_cmd                    r_s2_cmd;
    logic [derh_pkg::RED_BITS-1:0]     r_red_lo,   n_red_lo,   r_red_hi,   n_red_hi;
    logic [derh_pkg::GREEN_BITS-1:0]   r_green_lo, n_green_lo, r_green_hi, n_green_hi;
    logic [derh_pkg::BLUE_BITS-1:0]    r_blue_lo,  n_blue_lo,  r_blue_hi,  n_blue_hi;

    logic                  issue;
    logic                  acc;
    logic                  restart;
    logic [CNT_BITS-1:0]   out_count;
    logic                  out_empty;
    logic                  out_full;
    logic                  out_pop;
    logic [COUNT_BITS-1:0] red_cnt, green_cnt, blue_cnt, sel_cnt;
    logic [OUT_BITS-1:0]   clip_cnt;
    derh_pkg::t_result     res;

    logic [derh_pkg::RED_BITS-1:0]   red_a,   red_b;
    logic [derh_pkg::GREEN_BITS-1:0] green_a, green_b;
    logic [derh_pkg::BLUE_BITS-1:0]  blue_a,  blue_b;

    // issue only when the result queue has room for everything in flight
    assign issue = !i_cmd_empty &&
                   (r_s2_vld ? (out_count < CNT_BITS'(OUT_DEPTH - 1))
                             : (out_count < CNT_BITS'(OUT_DEPTH)));
    assign o_cmd_pop = issue;

    always_comb begin
        if (i_cmd.acc) begin
            red_a   = i_cmd.red0;
            red_b   = i_cmd.red1;
            green_a = i_cmd.green0;
            green_b = i_cmd.green1;
            blue_a  = i_cmd.blue0;
            blue_b  = i_cmd.blue1;
        end else begin
            red_a   = i_cmd.bin[derh_pkg::RED_BITS-1:0];
            red_b   = i_cmd.bin[derh_pkg::RED_BITS-1:0];
            green_a = i_cmd.bin[derh_pkg::GREEN_BITS-1:0];
            green_b = i_cmd.bin[derh_pkg::GREEN_BITS-1:0];
            blue_a  = i_cmd.bin[derh_pkg::BLUE_BITS-1:0];
            blue_b  = i_cmd.bin[derh_pkg::BLUE_BITS-1:0];
        end
    end

    assign acc     = r_s2_vld && r_s2_cmd.acc;
    assign restart = r_s2_vld && r_s2_cmd.restart;

    derh_hist #(
        .BIN_BITS   (derh_pkg::RED_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (red_a),
        .i_raddr_b (red_b),
        .i_acc     (acc && i_en.red),
        .i_clear   (restart),
        .o_count   (red_cnt)
    );

    derh_hist #(
        .BIN_BITS   (derh_pkg::GREEN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_green (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (green_a),
        .i_raddr_b (green_b),
        .i_acc     (acc && i_en.green),
        .i_clear   (restart),
        .o_count   (green_cnt)
    );

    derh_hist #(
        .BIN_BITS   (derh_pkg::BLUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_blue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (blue_a),
        .i_raddr_b (blue_b),
        .i_acc     (acc && i_en.blue),
        .i_clear   (restart),
        .o_count   (blue_cnt)
    );

    always_comb begin
        n_red_lo   = r_red_lo;
        n_red_hi   = r_red_hi;
        n_green_lo = r_green_lo;
        n_green_hi = r_green_hi;
        n_blue_lo  = r_blue_lo;
        n_blue_hi  = r_blue_hi;
        if (restart) begin
            n_red_lo   = derh_pkg::RED_LOW_RST;
            n_red_hi   = derh_pkg::RED_HIGH_RST;
            n_green_lo = derh_pkg::GREEN_LOW_RST;
            n_green_hi = derh_pkg::GREEN_HIGH_RST;
            n_blue_lo  = derh_pkg::BLUE_LOW_RST;
            n_blue_hi  = derh_pkg::BLUE_HIGH_RST;
        end else if (acc) begin
            if (r_s2_cmd.red0 < n_red_lo)     n_red_lo   = r_s2_cmd.red0;
            if (r_s2_cmd.red1 < n_red_lo)     n_red_lo   = r_s2_cmd.red1;
            if (r_s2_cmd.red0 > n_red_hi)     n_red_hi   = r_s2_cmd.red0;
            if (r_s2_cmd.red1 > n_red_hi)     n_red_hi   = r_s2_cmd.red1;
            if (r_s2_cmd.green0 < n_green_lo) n_green_lo = r_s2_cmd.green0;
            if (r_s2_cmd.green1 < n_green_lo) n_green_lo = r_s2_cmd.green1;
            if (r_s2_cmd.green0 > n_green_hi) n_green_hi = r_s2_cmd.green0;
            if (r_s2_cmd.green1 > n_green_hi) n_green_hi = r_s2_cmd.green1;
            if (r_s2_cmd.blue0 < n_blue_lo)   n_blue_lo  = r_s2_cmd.blue0;
            if (r_s2_cmd.blue1 < n_blue_lo)   n_blue_lo  = r_s2_cmd.blue1;
            if (r_s2_cmd.blue0 > n_blue_hi)   n_blue_hi  = r_s2_cmd.blue0;
            if (r_s2_cmd.blue1 > n_blue_hi)   n_blue_hi  = r_s2_cmd.blue1;
        end
    end

    always_comb begin
        if (r_s2_cmd.rd_red) begin
            sel_cnt = red_cnt;
        end else if (r_s2_cmd.rd_green) begin
            sel_cnt = green_cnt;
        end else if (r_s2_cmd.rd_blue) begin
            sel_cnt = blue_cnt;
        end else begin
            sel_cnt = '0;
        end
    end

    if (COUNT_BITS > OUT_BITS) begin : g_clip
        assign clip_cnt = (|sel_cnt[COUNT_BITS-1:OUT_BITS]) ? '1 : sel_cnt[OUT_BITS-1:0];
    end else begin : g_ext
        assign clip_cnt = OUT_BITS'(sel_cnt);
    end

    always_comb begin
        res.min_packed = {n_blue_lo, n_green_lo, n_red_lo};
        res.max_packed = {n_blue_hi, n_green_hi, n_red_hi};
        res.bin_count  = clip_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld   <= 1'b0;
            r_red_lo   <= derh_pkg::RED_LOW_RST;
            r_red_hi   <= derh_pkg::RED_HIGH_RST;
            r_green_lo <= derh_pkg::GREEN_LOW_RST;
            r_green_hi <= derh_pkg::GREEN_HIGH_RST;
            r_blue_lo  <= derh_pkg::BLUE_LOW_RST;
            r_blue_hi  <= derh_pkg::BLUE_HIGH_RST;
        end else begin
            r_s2_vld   <= issue;
            r_red_lo   <= n_red_lo;
            r_red_hi   <= n_red_hi;
            r_green_lo <= n_green_lo;
            r_green_hi <= n_green_hi;
            r_blue_lo  <= n_blue_lo;
            r_blue_hi  <= n_blue_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2_cmd <= i_cmd;
        end
    end

    assign out_pop = !out_empty && !i_stall;

    derh_fifo #(
        .WIDTH ($bits(derh_pkg::t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_vld),
        .i_data  (res),
        .i_pop   (out_pop),
        .o_data  (o_result),
        .o_empty (out_empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    assign o_valid = !out_empty;

    always_comb begin
        o_status.issue    = issue;
        o_status.s2_vld   = r_s2_vld;
        o_status.out_full = out_full;
    end

endmodule

@@ hdl/dxt_endpoint_range_histogram.sv @@
// Top level of the DXT endpoint range and histogram unit
// Takes one item per clock while o_stall is low and returns one result per item. The
// result passes through the front register, the command queue, the stage-two register
// and the result queue before it is offered, and waits there while i_stall is high. Each
// accumulate item carries the two RGB565 endpoints of a compressed colour block; the unit
// tracks running per-channel minima and maxima and, per enabled channel, saturating
// histogram counts (32 red, 64 green, 32 blue bins). Each channel's histogram is held in
// two RAM banks, one per endpoint, so both endpoints are counted in the same
// cycle through a read-modify-write with one-deep forwarding; a bin read sums
// the two banks. The read-modify-write loop of those banks sets the rate of one item
// per cycle, which holds while neither the command queue nor the result queue is full.
// Per-entry valid bits make reset and restart take effect at once, so there is no clearing
// pass. The user must write enables only while the unit is idle; it does not enforce this.
module dxt_endpoint_range_histogram #(
    parameter int COUNT_BITS = derh_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [derh_pkg::KIND_BITS-1:0]      i_kind,
    input  logic [derh_pkg::RED_BITS-1:0]       i_red0,
    input  logic [derh_pkg::GREEN_BITS-1:0]     i_green0,
    input  logic [derh_pkg::BLUE_BITS-1:0]      i_blue0,
    input  logic [derh_pkg::RED_BITS-1:0]       i_red1,
    input  logic [derh_pkg::GREEN_BITS-1:0]     i_green1,
    input  logic [derh_pkg::BLUE_BITS-1:0]      i_blue1,
    input  logic [derh_pkg::CHAN_BITS-1:0]      i_channel,
    input  logic [derh_pkg::BIN_IDX_BITS-1:0]   i_bin,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [derh_pkg::PACKED_BITS-1:0]    o_min_packed,
    output logic [derh_pkg::PACKED_BITS-1:0]    o_max_packed,
    output logic [derh_pkg::OUT_COUNT_BITS-1:0] o_bin_count,
    input  logic                                i_cfg_we,
    input  logic [derh_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [derh_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

`include "dxt_endpoint_range_histogram_assert.svh"

    derh_pkg::t_hist_en     r_en;
    derh_pkg::t_cmd         fr_cmd;
    derh_pkg::t_cmd         q_cmd;
    derh_pkg::t_result      result;
    derh_pkg::t_back_status st;
    logic                   fr_push;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [$clog2(derh_pkg::CMD_QUEUE_DEPTH+1)-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                derh_pkg::REG_RED_EN:   r_en.red   <= i_cfg_data[0];
                derh_pkg::REG_GREEN_EN: r_en.green <= i_cfg_data[0];
                derh_pkg::REG_BLUE_EN:  r_en.blue  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    derh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_kind    (i_kind),
        .i_red0    (i_red0),
        .i_green0  (i_green0),
        .i_blue0   (i_blue0),
        .i_red1    (i_red1),
        .i_green1  (i_green1),
        .i_blue1   (i_blue1),
        .i_channel (i_channel),
        .i_bin     (i_bin),
        .i_full    (q_full),
        .o_push    (fr_push),
        .o_cmd     (fr_cmd)
    );

    derh_fifo #(
        .WIDTH ($bits(derh_pkg::t_cmd)),
        .DEPTH (derh_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_cmd),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    derh_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (r_en),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (result),
        .o_status    (st)
    );

    assign o_min_packed = result.min_packed;
    assign o_max_packed = result.max_packed;
    assign o_bin_count  = result.bin_count;

    `DERH_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, fr_push, !q_full)
    `DERH_ASSERT_IMPLY(a_issue_has_cmd, i_clk, i_rst_n, st.issue, !q_empty)
    `DERH_ASSERT_IMPLY(a_out_room, i_clk, i_rst_n, st.s2_vld, !st.out_full)
    `DERH_ASSERT_NEVER(a_count_range, i_clk, i_rst_n,
                       q_count > ($clog2(derh_pkg::CMD_QUEUE_DEPTH+1))'(derh_pkg::CMD_QUEUE_DEPTH))

endmodule
